/* rtl/core/wss_pkg.sv */
// Shared types for the work-stealing task scheduler.
// Controller state encoding plus the command and status bundles
// between the controller and the datapath. No dependencies.
package wss_pkg;

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_PUSH      = 7'b0000010,
		ST_STEAL_CHK = 7'b0000100,
		ST_STEAL_WR  = 7'b0001000,
		ST_WORK_CHK  = 7'b0010000,
		ST_WORK_UPD  = 7'b0100000,
		ST_EMIT      = 7'b1000000
	} state_t;

	typedef struct packed {
		logic latch;      // capture the incoming tick
		logic push;       // append the new task
		logic steal_rd;   // pop victim rear, read its entry
		logic steal_wr;   // append stolen entry to current worker
		logic work_rd;    // read current worker front entry
		logic work_upd;   // apply one step to the front task
		logic work_idle;  // record an idle row
		logic emit;       // present current worker row
	} cmd_t;

	typedef struct packed {
		logic steal_need; // current worker empty and a victim exists
		logic active;     // current worker holds tasks
	} status_t;

	localparam int ID_W    = 16;
	localparam int TIME_W  = 4;
	localparam int ENTRY_W = ID_W + TIME_W;

endpackage

/* rtl/core/work_stealing_task_scheduler_top.sv */
// Top level of the work-stealing task scheduler.
// Instantiates wss_ctrl and wss_dp; depends on wss_pkg.
//
// One tick is transferred when start is high and busy is low. The tick may
// carry a new task for one worker; the block then lets empty workers steal,
// steps every worker's front task and reports one row per worker, in worker
// order, each on the result ports for a single cycle with strobe high; the
// final row has last set. The receiver cannot stall: every strobed row must
// be taken in that cycle. The steal pass, the work pass and the row pass
// visit the workers in worker order; each steal and each front-task step
// uses the single-port task store for one read and, for a steal, one
// write. The last row is on the output register in the same cycle that
// busy drops. No clearing pass follows reset: the task store is only read
// at entries that were written before.
module work_stealing_task_scheduler_top #(
	parameter int NUM_WORKERS = 3,
	parameter int QUEUE_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        task_valid,
	input  logic [2:0]  target_worker,
	input  logic [15:0] new_task_id,
	input  logic [3:0]  new_task_time,
	output logic        strobe,
	output logic [2:0]  worker_index,
	output logic [6:0]  queue_count,
	output logic [15:0] front_task_id,
	output logic [3:0]  remaining_units,
	output logic        worked,
	output logic        finished,
	output logic        stole,
	output logic [2:0]  stolen_from,
	output logic        dropped,
	output logic [31:0] work_total,
	output logic        last
);
	import wss_pkg::*;

	// worker index width; one bit even for a single worker
	localparam int WW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;

	cmd_t          cmd;
	status_t       st;
	logic [WW-1:0] widx;

	// sequence the phases of a tick
	wss_ctrl #(
		.NUM_WORKERS(NUM_WORKERS),
		.WW(WW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.st(st),
		.cmd(cmd),
		.widx(widx)
	);

	// hold queues, task store and the row output register
	wss_dp #(
		.NUM_WORKERS(NUM_WORKERS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.WW(WW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.widx(widx),
		.st(st),
		.task_valid(task_valid),
		.target_worker(target_worker),
		.new_task_id(new_task_id),
		.new_task_time(new_task_time),
		.strobe(strobe),
		.worker_index(worker_index),
		.queue_count(queue_count),
		.front_task_id(front_task_id),
		.remaining_units(remaining_units),
		.worked(worked),
		.finished(finished),
		.stole(stole),
		.stolen_from(stolen_from),
		.dropped(dropped),
		.work_total(work_total),
		.last(last)
	);

endmodule

/* rtl/core/wss_ctrl.sv */
// Sequencer for the scheduler: walks the workers through the push,
// steal, work and row output phases of one tick.
// Depends on wss_pkg.
module wss_ctrl #(
	parameter int NUM_WORKERS = 3,
	parameter int WW = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  wss_pkg::status_t st,
	output wss_pkg::cmd_t    cmd,
	output logic [WW-1:0]    widx
);
	import wss_pkg::*;

	state_t        state_q, state_d;
	logic [WW-1:0] widx_q, widx_d;
	logic          last_w;

	assign last_w = (widx_q == WW'(NUM_WORKERS - 1));
	assign busy   = (state_q != ST_IDLE);
	assign widx   = widx_q;

	always_comb begin
		state_d = state_q;
		widx_d  = widx_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = ST_PUSH;
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				widx_d   = '0;
				state_d  = ST_STEAL_CHK;
			end
			ST_STEAL_CHK: begin
				if (st.steal_need) begin
					cmd.steal_rd = 1'b1;
					state_d      = ST_STEAL_WR;
				end else if (last_w) begin
					widx_d  = '0;
					state_d = ST_WORK_CHK;
				end else begin
					widx_d = widx_q + 1'b1;
				end
			end
			ST_STEAL_WR: begin
				cmd.steal_wr = 1'b1;
				if (last_w) begin
					widx_d  = '0;
					state_d = ST_WORK_CHK;
				end else begin
					widx_d  = widx_q + 1'b1;
					state_d = ST_STEAL_CHK;
				end
			end
			ST_WORK_CHK: begin
				if (st.active) begin
					cmd.work_rd = 1'b1;
					state_d     = ST_WORK_UPD;
				end else begin
					cmd.work_idle = 1'b1;
					if (last_w) begin
						widx_d  = '0;
						state_d = ST_EMIT;
					end else begin
						widx_d = widx_q + 1'b1;
					end
				end
			end
			ST_WORK_UPD: begin
				cmd.work_upd = 1'b1;
				if (last_w) begin
					widx_d  = '0;
					state_d = ST_EMIT;
				end else begin
					widx_d  = widx_q + 1'b1;
					state_d = ST_WORK_CHK;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (last_w) begin
					widx_d  = '0;
					state_d = ST_IDLE;
				end else begin
					widx_d = widx_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
				widx_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			widx_q  <= '0;
		end else begin
			state_q <= state_d;
			widx_q  <= widx_d;
		end
	end

endmodule

/* rtl/core/wss_dp.sv */
// Datapath for the scheduler: task store memory, per-worker ring
// pointers and counts, per-tick row records and the output register.
// Depends on wss_pkg.
module wss_dp #(
	parameter int NUM_WORKERS = 3,
	parameter int QUEUE_DEPTH = 128,
	parameter int WW = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  wss_pkg::cmd_t    cmd,
	input  logic [WW-1:0]    widx,
	output wss_pkg::status_t st,
	input  logic             task_valid,
	input  logic [2:0]       target_worker,
	input  logic [15:0]      new_task_id,
	input  logic [3:0]       new_task_time,
	output logic             strobe,
	output logic [2:0]       worker_index,
	output logic [6:0]       queue_count,
	output logic [15:0]      front_task_id,
	output logic [3:0]       remaining_units,
	output logic             worked,
	output logic             finished,
	output logic             stole,
	output logic [2:0]       stolen_from,
	output logic             dropped,
	output logic [31:0]      work_total,
	output logic             last
);
	import wss_pkg::*;

	localparam int NW = NUM_WORKERS;
	localparam int QD = QUEUE_DEPTH;
	localparam int PW = $clog2(QD);
	localparam int AW = $clog2(NW * QD);

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == PW'(QD - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
		return (p == '0) ? PW'(QD - 1) : p - 1'b1;
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [WW-1:0] w,
			input logic [PW-1:0] p);
		return AW'(w) * AW'(QD) + AW'(p);
	endfunction

	logic [ENTRY_W-1:0] mem [NW*QD];
	logic [ENTRY_W-1:0] rdata_q;

	logic [PW-1:0] head_q  [NW];
	logic [PW-1:0] tail_q  [NW];
	logic [PW-1:0] count_q [NW];
	logic [3:0]    rem_q   [NW];
	logic [31:0]   total_q;

	logic          stole_q  [NW];
	logic [WW-1:0] victim_q [NW];
	logic          drop_q   [NW];
	logic          bad_q;
	logic [15:0]   fid_q    [NW];
	logic          worked_q [NW];
	logic          fin_q    [NW];

	logic          in_valid_q;
	logic [2:0]    in_tgt_q;
	logic [15:0]   in_id_q;
	logic [3:0]    in_time_q;

	logic          vfound;
	logic [WW-1:0] vsel;
	logic          tgt_bad;
	logic [WW-1:0] tidx;
	logic          full_t;
	logic          do_push;
	logic [3:0]    nrem;
	logic          nwork;
	logic [PW-1:0] vtail_prev;

	// first worker holding more than one task
	always_comb begin
		vfound = 1'b0;
		vsel   = '0;
		for (int v = NW - 1; v >= 0; v--) begin
			if (count_q[v] > PW'(1)) begin
				vfound = 1'b1;
				vsel   = WW'(v);
			end
		end
	end

	assign st.steal_need = (count_q[widx] == '0) && vfound;
	assign st.active     = (count_q[widx] != '0);

	assign tgt_bad    = ({1'b0, in_tgt_q} >= 4'(NW));
	assign tidx       = in_tgt_q[WW-1:0];
	assign full_t     = (count_q[tidx] >= PW'(QD - 1));
	assign do_push    = cmd.push && in_valid_q && !tgt_bad && !full_t;
	assign vtail_prev = ring_prev(tail_q[vsel]);

	always_comb begin
		nwork = (rem_q[widx] != 4'd0);
		nrem  = nwork ? rem_q[widx] - 4'd1 : rdata_q[TIME_W-1:0];
	end

	// task store
	always_ff @(posedge clk) begin
		if (do_push)
			mem[addr_of(tidx, tail_q[tidx])] <= {in_id_q, in_time_q};
		else if (cmd.steal_wr)
			mem[addr_of(widx, tail_q[widx])] <= rdata_q;
		if (cmd.steal_rd)
			rdata_q <= mem[addr_of(vsel, vtail_prev)];
		else if (cmd.work_rd)
			rdata_q <= mem[addr_of(widx, head_q[widx])];
	end

	// queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < NW; w++) begin
				head_q[w]  <= '0;
				tail_q[w]  <= '0;
				count_q[w] <= '0;
				rem_q[w]   <= '0;
			end
			total_q <= '0;
			strobe  <= 1'b0;
		end else begin
			strobe <= cmd.emit;
			if (do_push) begin
				tail_q[tidx]  <= ring_next(tail_q[tidx]);
				count_q[tidx] <= count_q[tidx] + 1'b1;
			end
			if (cmd.steal_rd) begin
				tail_q[vsel]  <= vtail_prev;
				count_q[vsel] <= count_q[vsel] - 1'b1;
			end
			if (cmd.steal_wr) begin
				tail_q[widx]  <= ring_next(tail_q[widx]);
				count_q[widx] <= count_q[widx] + 1'b1;
			end
			if (cmd.work_upd) begin
				rem_q[widx] <= nrem;
				if (nwork)
					total_q <= total_q + 32'd1;
				if (nrem == 4'd0) begin
					head_q[widx]  <= ring_next(head_q[widx]);
					count_q[widx] <= count_q[widx] - 1'b1;
				end
			end
		end
	end

	// per-tick row records and output register
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			in_valid_q <= task_valid;
			in_tgt_q   <= target_worker;
			in_id_q    <= new_task_id;
			in_time_q  <= new_task_time;
			for (int w = 0; w < NW; w++) begin
				stole_q[w]  <= 1'b0;
				victim_q[w] <= '0;
				drop_q[w]   <= 1'b0;
			end
		end
		if (cmd.push) begin
			bad_q <= in_valid_q && tgt_bad;
			if (in_valid_q && !tgt_bad && full_t)
				drop_q[tidx] <= 1'b1;
		end
		if (cmd.steal_rd) begin
			stole_q[widx]  <= 1'b1;
			victim_q[widx] <= vsel;
		end
		if (cmd.work_idle) begin
			fid_q[widx]    <= '0;
			worked_q[widx] <= 1'b0;
			fin_q[widx]    <= 1'b0;
		end
		if (cmd.work_upd) begin
			fid_q[widx]    <= rdata_q[ENTRY_W-1:TIME_W];
			worked_q[widx] <= nwork;
			fin_q[widx]    <= (nrem == 4'd0);
		end
		if (cmd.emit) begin
			worker_index    <= 3'(widx);
			queue_count     <= 7'(count_q[widx]);
			front_task_id   <= fid_q[widx];
			remaining_units <= rem_q[widx];
			worked          <= worked_q[widx];
			finished        <= fin_q[widx];
			stole           <= stole_q[widx];
			stolen_from     <= 3'(victim_q[widx]);
			dropped         <= drop_q[widx] ||
				(bad_q && (widx == WW'(NW - 1)));
			work_total      <= total_q;
			last            <= (widx == WW'(NW - 1));
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[widx] <= PW'(QD - 1))
		else $error("queue count above capacity");
	a_steal_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.steal_rd |-> vfound && count_q[widx] == '0)
		else $error("steal without empty thief or victim");
	a_work_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.work_rd |=> cmd.work_upd && count_q[widx] != '0)
		else $error("front read not followed by update");
	a_steal_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.steal_rd |=> cmd.steal_wr)
		else $error("stolen entry not appended");

endmodule
